// ----- src/contact_impulse_defines.svh -----
// contact_impulse_defines.svh: assertion macros shared by the contact impulse RTL.
// Expects clk and rst in the scope of each use.
`ifndef CONTACT_IMPULSE_DEFINES_SVH
`define CONTACT_IMPULSE_DEFINES_SVH

// same-cycle implication
`define CI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ci_pkg.sv -----
// ci_pkg: types, constants and fixed point helpers for the contact impulse block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ci_pkg;

  localparam int CI_W        = 32;              // Q15.16 word
  localparam int CI_FRAC     = 16;
  localparam int CI_RW       = 2 * CI_W - CI_FRAC; // rounded product
  localparam int CI_SW       = CI_RW + 2;       // sum of three products
  localparam int CI_DW       = CI_W + CI_FRAC;  // scaled dividend
  localparam int CI_EW       = 17;              // Q1.16 factor
  localparam int CI_MW       = 31;              // mass
  localparam int CI_DIV_BITS = 2;               // quotient bits per divider stage

  typedef logic signed [CI_W-1:0]  fx_t;
  typedef logic signed [CI_RW-1:0] raw_t;
  typedef logic signed [CI_SW-1:0] sum_t;
  typedef logic [CI_EW-1:0]        frac_t;
  typedef logic [CI_MW-1:0]        mass_t;
  typedef logic [2:0]              cfg_idx_t;

  localparam cfg_idx_t REG_MASS = 3'd0;
  localparam cfg_idx_t REG_IXX  = 3'd1;
  localparam cfg_idx_t REG_IYY  = 3'd2;
  localparam cfg_idx_t REG_IZZ  = 3'd3;
  localparam cfg_idx_t REG_IXY  = 3'd4;
  localparam cfg_idx_t REG_IXZ  = 3'd5;
  localparam cfg_idx_t REG_IYZ  = 3'd6;

  localparam fx_t   CI_MAX   = {1'b0, {(CI_W-1){1'b1}}};
  localparam fx_t   CI_MIN   = {1'b1, {(CI_W-1){1'b0}}};
  localparam fx_t   CI_ONE   = fx_t'(1 << CI_FRAC);
  localparam mass_t CI_MASS1 = mass_t'(1 << CI_FRAC);
  localparam logic [CI_EW:0] CI_ONE_E = (CI_EW+1)'(1 << CI_FRAC);

  typedef struct packed {
    fx_t   arm_x;
    fx_t   arm_y;
    fx_t   arm_z;
    fx_t   vel_x;
    fx_t   vel_y;
    fx_t   vel_z;
    fx_t   norm_x;
    fx_t   norm_y;
    fx_t   norm_z;
    frac_t bounce;
    frac_t grip;
  } item_t;

  typedef struct packed {
    fx_t  push_x;
    fx_t  push_y;
    fx_t  push_z;
    logic degenerate;
  } result_t;

  // product rounded half up, floor shift
  function automatic raw_t mul_raw(fx_t a, fx_t b);
    logic signed [2*CI_W-1:0] p;
    p = a * b;
    p = p + (2*CI_W)'(1 << (CI_FRAC - 1));
    return p[2*CI_W-1:CI_FRAC];
  endfunction

  function automatic fx_t sat(sum_t x);
    if (x > sum_t'(CI_MAX)) return CI_MAX;
    if (x < sum_t'(CI_MIN)) return CI_MIN;
    return x[CI_W-1:0];
  endfunction

  function automatic fx_t mul(fx_t a, fx_t b);
    return sat(sum_t'(mul_raw(a, b)));
  endfunction

endpackage

`default_nettype wire

// ----- src/ci_delay.sv -----
// ci_delay: enabled shift line that carries side data past a divider.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ci_delay #(
  parameter int W     = 8,
  parameter int Depth = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < Depth; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[Depth-1];

endmodule

`default_nettype wire

// ----- src/ci_div.sv -----
// ci_div: pipelined signed Q15.16 quotient (a * 2^16) / b, truncated and saturated.
// Depends on ci_pkg. The operands, each divider stage and the saturated result are registered.
`timescale 1ns / 1ps
`default_nettype none

module ci_div #(
  parameter int BitsPerStage = ci_pkg::CI_DIV_BITS
) (
  input  logic            clk,
  input  logic            en,
  input  ci_pkg::fx_t     num,
  input  ci_pkg::fx_t     den,
  output ci_pkg::fx_t     quo
);
  import ci_pkg::*;

  localparam int Steps = CI_DW / BitsPerStage;
  localparam logic [CI_DW-1:0] MagMin = {{(CI_DW-CI_W){1'b0}}, 1'b1, {(CI_W-1){1'b0}}};

  logic [CI_W:0]    num_abs;
  logic [CI_W:0]    den_abs;
  logic [CI_W-1:0]  rem [Steps+1];
  logic [CI_DW-1:0] dvd [Steps+1];
  logic [CI_DW-1:0] qt  [Steps+1];
  logic [CI_W-1:0]  dvs [Steps+1];
  logic             neg [Steps+1];

  assign num_abs = num[CI_W-1] ? (~{1'b1, num}) + 1'b1 : {1'b0, num};
  assign den_abs = den[CI_W-1] ? (~{1'b1, den}) + 1'b1 : {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dvd[0] <= {num_abs[CI_W-1:0], {CI_FRAC{1'b0}}};
      qt[0]  <= '0;
      dvs[0] <= den_abs[CI_W-1:0];
      neg[0] <= num[CI_W-1] ^ den[CI_W-1];
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [CI_W-1:0]  rem_next;
    logic [CI_DW-1:0] dvd_next;
    logic [CI_DW-1:0] qt_next;

    always_comb begin
      logic [CI_W:0] sh;
      rem_next = rem[s];
      dvd_next = dvd[s];
      qt_next  = qt[s];
      for (int b = 0; b < BitsPerStage; b++) begin
        sh       = {rem_next, dvd_next[CI_DW-1]};
        dvd_next = {dvd_next[CI_DW-2:0], 1'b0};
        if (sh >= {1'b0, dvs[s]}) begin
          sh      = sh - {1'b0, dvs[s]};
          qt_next = {qt_next[CI_DW-2:0], 1'b1};
        end else begin
          qt_next = {qt_next[CI_DW-2:0], 1'b0};
        end
        rem_next = sh[CI_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        dvd[s+1] <= dvd_next;
        qt[s+1]  <= qt_next;
        dvs[s+1] <= dvs[s];
        neg[s+1] <= neg[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[Steps]) begin
        if (qt[Steps] > MagMin) begin
          quo <= CI_MIN;
        end else begin
          quo <= (~qt[Steps][CI_W-1:0]) + 1'b1;
        end
      end else begin
        if (qt[Steps] > MagMin - 1'b1) begin
          quo <= CI_MAX;
        end else begin
          quo <= qt[Steps][CI_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/contact_impulse.sv -----
// contact_impulse: top level of the rigid body contact impulse pipeline.
// Depends on ci_pkg, ci_div, ci_delay and contact_impulse_defines.svh.
// Takes one request per cycle while the output stage is not held and returns one result
// per request, in order. Two chained long dividers lie on the path (the denominator
// quotients, then the normal impulse quotient). A full output stage that is not taken
// holds the whole pipeline; the configuration port is always ready and is to be written
// only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module contact_impulse #(
  parameter int DivBitsPerStage = ci_pkg::CI_DIV_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ci_pkg::item_t    item,
  output logic             result_valid,
  input  logic             result_ready,
  output ci_pkg::result_t  result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  ci_pkg::cfg_idx_t cfg_index,
  input  ci_pkg::fx_t      cfg_data
);
  import ci_pkg::*;
  `include "contact_impulse_defines.svh"

  localparam int DivLat = CI_DW / DivBitsPerStage + 2;
  localparam int N      = 11 + 2 * DivLat;
  localparam int CofIdx [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

  typedef struct packed {
    fx_t       ep;
    fx_t [2:0] vel;
    fx_t [2:0] nrm;
    frac_t     f;
    logic      deg;
  } side1_t;

  typedef struct packed {
    fx_t [2:0] tp;
    fx_t [2:0] vel;
    fx_t [2:0] nrm;
    frac_t     f;
    logic      deg;
  } side2_t;

  logic en;
  logic [N-1:0] vld;

  mass_t mass;
  fx_t ixx, iyy, izz, ixy, ixz, iyz;
  fx_t cof_a [6], cof_b [6], cof_c [6], cof_d [6];

  // stage registers
  fx_t   s1_arm [3], s1_vel [3], s1_nrm [3];
  frac_t s1_e, s1_f;
  raw_t  s2_nn_p [3], s2_vn_p [3], s2_cof_p [6][2], s2_c_p [3][2];
  fx_t   s2_vel [3], s2_nrm [3];
  frac_t s2_e, s2_f;
  fx_t   s3_nn, s3_vn, s3_cof [6], s3_c [3], s3_vel [3], s3_nrm [3];
  frac_t s3_e, s3_f;
  raw_t  s4_det_p [3], s4_w_p [3][3];
  fx_t   s4_ep, s4_nn, s4_vn, s4_c [3], s4_vel [3], s4_nrm [3];
  frac_t s4_f;
  fx_t   s5_det, s5_w [3], s5_ep, s5_nn, s5_vn, s5_c [3], s5_vel [3], s5_nrm [3];
  frac_t s5_f;
  raw_t  s6_q_p [3];
  fx_t   s6_det, s6_ep, s6_nn, s6_vn, s6_vel [3], s6_nrm [3];
  frac_t s6_f;
  fx_t   s7_q, s7_det, s7_ep, s7_nn, s7_vn, s7_vel [3], s7_nrm [3];
  frac_t s7_f;
  logic  s7_deg;
  fx_t   s8_den, s8_ep;
  side2_t s8_side;
  fx_t   s9_nk [3], s9_d [3];
  frac_t s9_f;
  logic  s9_deg;
  fx_t   s10_nk [3], s10_fd [3];
  logic  s10_deg;
  result_t s11;

  fx_t    inv_q, rot_q, t_q, k_q, den_c;
  side1_t side1_in, side1_out;
  side2_t side2_out;
  logic [17:0] ope;

  assign en         = !vld[N-1] || result_ready;
  assign item_ready = en;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= CI_MASS1;
      ixx  <= CI_ONE;
      iyy  <= CI_ONE;
      izz  <= CI_ONE;
      ixy  <= '0;
      ixz  <= '0;
      iyz  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MASS: mass <= cfg_data[CI_MW-1:0];
        REG_IXX:  ixx  <= cfg_data;
        REG_IYY:  iyy  <= cfg_data;
        REG_IZZ:  izz  <= cfg_data;
        REG_IXY:  ixy  <= cfg_data;
        REG_IXZ:  ixz  <= cfg_data;
        REG_IYZ:  iyz  <= cfg_data;
        default: ;
      endcase
    end
  end

  // cofactor k = a*b - c*d, order xx xy xz yy yz zz
  assign cof_a = '{iyy, iyz, ixy, ixx, ixy, ixx};
  assign cof_b = '{izz, ixz, iyz, izz, ixz, iyy};
  assign cof_c = '{iyz, ixy, iyy, ixz, ixx, ixy};
  assign cof_d = '{iyz, izz, ixz, ixz, iyz, ixy};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_arm <= '{item.arm_x, item.arm_y, item.arm_z};
      s1_vel <= '{item.vel_x, item.vel_y, item.vel_z};
      s1_nrm <= '{item.norm_x, item.norm_y, item.norm_z};
      s1_e   <= item.bounce;
      s1_f   <= item.grip;

      for (int i = 0; i < 3; i++) begin
        s2_nn_p[i] <= mul_raw(s1_nrm[i], s1_nrm[i]);
        s2_vn_p[i] <= mul_raw(s1_vel[i], s1_nrm[i]);
      end
      for (int k = 0; k < 6; k++) begin
        s2_cof_p[k][0] <= mul_raw(cof_a[k], cof_b[k]);
        s2_cof_p[k][1] <= mul_raw(cof_c[k], cof_d[k]);
      end
      s2_c_p[0][0] <= mul_raw(s1_arm[1], s1_nrm[2]);
      s2_c_p[0][1] <= mul_raw(s1_arm[2], s1_nrm[1]);
      s2_c_p[1][0] <= mul_raw(s1_arm[2], s1_nrm[0]);
      s2_c_p[1][1] <= mul_raw(s1_arm[0], s1_nrm[2]);
      s2_c_p[2][0] <= mul_raw(s1_arm[0], s1_nrm[1]);
      s2_c_p[2][1] <= mul_raw(s1_arm[1], s1_nrm[0]);
      s2_vel <= s1_vel;
      s2_nrm <= s1_nrm;
      s2_e   <= s1_e;
      s2_f   <= s1_f;

      s3_nn <= sat(sum_t'(s2_nn_p[0]) + sum_t'(s2_nn_p[1]) + sum_t'(s2_nn_p[2]));
      s3_vn <= sat(sum_t'(s2_vn_p[0]) + sum_t'(s2_vn_p[1]) + sum_t'(s2_vn_p[2]));
      for (int k = 0; k < 6; k++) begin
        s3_cof[k] <= sat(sum_t'(s2_cof_p[k][0]) - sum_t'(s2_cof_p[k][1]));
      end
      for (int i = 0; i < 3; i++) begin
        s3_c[i] <= sat(sum_t'(s2_c_p[i][0]) - sum_t'(s2_c_p[i][1]));
      end
      s3_vel <= s2_vel;
      s3_nrm <= s2_nrm;
      s3_e   <= s2_e;
      s3_f   <= s2_f;

      s4_det_p[0] <= mul_raw(ixx, s3_cof[0]);
      s4_det_p[1] <= mul_raw(ixy, s3_cof[1]);
      s4_det_p[2] <= mul_raw(ixz, s3_cof[2]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s4_w_p[i][j] <= mul_raw(s3_cof[CofIdx[i][j]], s3_c[j]);
        end
      end
      s4_ep  <= mul({{(CI_W-18){1'b0}}, ope}, s3_vn);
      s4_nn  <= s3_nn;
      s4_vn  <= s3_vn;
      s4_c   <= s3_c;
      s4_vel <= s3_vel;
      s4_nrm <= s3_nrm;
      s4_f   <= s3_f;

      s5_det <= sat(sum_t'(s4_det_p[0]) + sum_t'(s4_det_p[1]) + sum_t'(s4_det_p[2]));
      for (int i = 0; i < 3; i++) begin
        s5_w[i] <= sat(sum_t'(s4_w_p[i][0]) + sum_t'(s4_w_p[i][1]) + sum_t'(s4_w_p[i][2]));
      end
      s5_ep  <= s4_ep;
      s5_nn  <= s4_nn;
      s5_vn  <= s4_vn;
      s5_c   <= s4_c;
      s5_vel <= s4_vel;
      s5_nrm <= s4_nrm;
      s5_f   <= s4_f;

      for (int i = 0; i < 3; i++) begin
        s6_q_p[i] <= mul_raw(s5_w[i], s5_c[i]);
      end
      s6_det <= s5_det;
      s6_ep  <= s5_ep;
      s6_nn  <= s5_nn;
      s6_vn  <= s5_vn;
      s6_vel <= s5_vel;
      s6_nrm <= s5_nrm;
      s6_f   <= s5_f;

      s7_q   <= sat(sum_t'(s6_q_p[0]) + sum_t'(s6_q_p[1]) + sum_t'(s6_q_p[2]));
      s7_deg <= (mass == '0) || (s6_nn == '0) || (s6_det == '0);
      s7_det <= s6_det;
      s7_ep  <= s6_ep;
      s7_nn  <= s6_nn;
      s7_vn  <= s6_vn;
      s7_vel <= s6_vel;
      s7_nrm <= s6_nrm;
      s7_f   <= s6_f;
    end
  end

  assign ope = {1'b0, s3_e} + CI_ONE_E;

  // first quotient bank: n.n/m, rotational term, projection scale
  ci_div #(.BitsPerStage(DivBitsPerStage)) u_div_inv (
    .clk(clk), .en(en), .num(s7_nn), .den({1'b0, mass}), .quo(inv_q)
  );
  ci_div #(.BitsPerStage(DivBitsPerStage)) u_div_rot (
    .clk(clk), .en(en), .num(s7_q), .den(s7_det), .quo(rot_q)
  );
  ci_div #(.BitsPerStage(DivBitsPerStage)) u_div_t (
    .clk(clk), .en(en), .num(s7_vn), .den(s7_nn), .quo(t_q)
  );

  assign side1_in = '{ep: s7_ep, vel: {s7_vel[2], s7_vel[1], s7_vel[0]},
                      nrm: {s7_nrm[2], s7_nrm[1], s7_nrm[0]}, f: s7_f, deg: s7_deg};

  ci_delay #(.W($bits(side1_t)), .Depth(DivLat)) u_side1 (
    .clk(clk), .en(en), .d(side1_in), .q(side1_out)
  );

  assign den_c = sat(sum_t'(inv_q) + sum_t'(rot_q));

  always_ff @(posedge clk) begin
    if (en) begin
      s8_den <= den_c;
      s8_ep  <= side1_out.ep;
      for (int i = 0; i < 3; i++) begin
        s8_side.tp[i] <= mul(side1_out.nrm[i], t_q);
      end
      s8_side.vel <= side1_out.vel;
      s8_side.nrm <= side1_out.nrm;
      s8_side.f   <= side1_out.f;
      s8_side.deg <= side1_out.deg || (den_c == '0);
    end
  end

  ci_div #(.BitsPerStage(DivBitsPerStage)) u_div_k (
    .clk(clk), .en(en), .num(s8_ep), .den(s8_den), .quo(k_q)
  );

  ci_delay #(.W($bits(side2_t)), .Depth(DivLat)) u_side2 (
    .clk(clk), .en(en), .d(s8_side), .q(side2_out)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s9_nk[i] <= mul(side2_out.nrm[i], k_q);
        s9_d[i]  <= sat(sum_t'(side2_out.tp[i]) - sum_t'(side2_out.vel[i]));
      end
      s9_f   <= side2_out.f;
      s9_deg <= side2_out.deg;

      for (int i = 0; i < 3; i++) begin
        s10_fd[i] <= mul({{(CI_W-CI_EW){1'b0}}, s9_f}, s9_d[i]);
      end
      s10_nk  <= s9_nk;
      s10_deg <= s9_deg;

      if (s10_deg) begin
        s11 <= '{push_x: '0, push_y: '0, push_z: '0, degenerate: 1'b1};
      end else begin
        s11.push_x     <= sat(sum_t'(s10_fd[0]) - sum_t'(s10_nk[0]));
        s11.push_y     <= sat(sum_t'(s10_fd[1]) - sum_t'(s10_nk[1]));
        s11.push_z     <= sat(sum_t'(s10_fd[2]) - sum_t'(s10_nk[2]));
        s11.degenerate <= 1'b0;
      end
    end
  end

  assign result       = s11;
  assign result_valid = vld[N-1];

  `CI_ASSERT_IMP(a_deg_zero, result_valid && result.degenerate, result.push_x == '0 && result.push_y == '0 && result.push_z == '0, "degenerate result with non-zero impulse")
  `CI_ASSERT_IMP(a_ready_free, !result_valid, item_ready, "input held with an empty output stage")
  `CI_ASSERT_NXT(a_valid_shift, en, vld[N-1] == $past(vld[N-2]), "valid lost or repeated in pipeline")

endmodule

`default_nettype wire

// ----- bench/ci_checker.sv -----
// ci_checker: watches the request, result and register channels of contact_impulse,
// predicts each impulse and compares it field by field. Depends on ci_pkg.
`timescale 1ns / 1ps

module ci_checker
  import ci_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_ready,
  input  item_t    item,
  input  logic     result_valid,
  input  logic     result_ready,
  input  result_t  result,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  fx_t      cfg_data,
  output int       fails,
  output int       pending
);

  longint  mass;
  longint  ixx, iyy, izz, ixy, ixz, iyz;
  result_t impulse_q[$];

  function automatic longint clamp(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint dot(longint a0, longint a1, longint a2,
                                 longint b0, longint b1, longint b2);
    return clamp(rmul(a0, b0) + rmul(a1, b1) + rmul(a2, b2));
  endfunction

  function automatic longint xprod(longint a, longint b, longint c, longint d);
    return clamp(rmul(a, b) - rmul(c, d));
  endfunction

  function automatic result_t impulse(item_t x);
    longint r[3], v[3], n[3], c[3], w[3], p[3];
    longint a00, a01, a02, a11, a12, a22;
    longint nn, inv, dt, q, rot, den, vn, k, t, d, e, f;
    result_t o;
    r[0] = x.arm_x;  r[1] = x.arm_y;  r[2] = x.arm_z;
    v[0] = x.vel_x;  v[1] = x.vel_y;  v[2] = x.vel_z;
    n[0] = x.norm_x; n[1] = x.norm_y; n[2] = x.norm_z;
    e = x.bounce;
    f = x.grip;
    o = '0;
    o.degenerate = 1'b1;
    nn  = dot(n[0], n[1], n[2], n[0], n[1], n[2]);
    a00 = xprod(iyy, izz, iyz, iyz);
    a01 = xprod(iyz, ixz, ixy, izz);
    a02 = xprod(ixy, iyz, iyy, ixz);
    a11 = xprod(ixx, izz, ixz, ixz);
    a12 = xprod(ixy, ixz, ixx, iyz);
    a22 = xprod(ixx, iyy, ixy, ixy);
    dt  = dot(ixx, ixy, ixz, a00, a01, a02);
    if (mass == 0 || nn == 0 || dt == 0) return o;
    inv  = clamp(nn * 65536 / mass);
    c[0] = xprod(r[1], n[2], r[2], n[1]);
    c[1] = xprod(r[2], n[0], r[0], n[2]);
    c[2] = xprod(r[0], n[1], r[1], n[0]);
    w[0] = dot(a00, a01, a02, c[0], c[1], c[2]);
    w[1] = dot(a01, a11, a12, c[0], c[1], c[2]);
    w[2] = dot(a02, a12, a22, c[0], c[1], c[2]);
    q    = dot(w[0], w[1], w[2], c[0], c[1], c[2]);
    rot  = clamp(q * 65536 / dt);
    den  = clamp(inv + rot);
    if (den == 0) return o;
    vn = dot(v[0], v[1], v[2], n[0], n[1], n[2]);
    k  = clamp(clamp(rmul(65536 + e, vn)) * 65536 / den);
    t  = clamp(vn * 65536 / nn);
    for (int i = 0; i < 3; i++) begin
      d    = clamp(clamp(rmul(n[i], t)) - v[i]);
      p[i] = clamp(-clamp(rmul(n[i], k)) + clamp(rmul(f, d)));
    end
    o.push_x = fx_t'(p[0]);
    o.push_y = fx_t'(p[1]);
    o.push_z = fx_t'(p[2]);
    o.degenerate = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mass = 65536;
      ixx = 65536; iyy = 65536; izz = 65536;
      ixy = 0; ixz = 0; iyz = 0;
      impulse_q.delete();
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS: mass = longint'(cfg_data[CI_MW-1:0]);
          REG_IXX:  ixx = cfg_data;
          REG_IYY:  iyy = cfg_data;
          REG_IZZ:  izz = cfg_data;
          REG_IXY:  ixy = cfg_data;
          REG_IXZ:  ixz = cfg_data;
          REG_IYZ:  iyz = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        impulse_q.push_back(impulse(item));
        pending++;
      end
      if (result_valid && result_ready) begin
        if (impulse_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = impulse_q.pop_front();
          pending--;
          if (result.push_x !== want.push_x) begin
            $error("push_x expected %0d got %0d", want.push_x, result.push_x);
            fails++;
          end
          if (result.push_y !== want.push_y) begin
            $error("push_y expected %0d got %0d", want.push_y, result.push_y);
            fails++;
          end
          if (result.push_z !== want.push_z) begin
            $error("push_z expected %0d got %0d", want.push_z, result.push_z);
            fails++;
          end
          if (result.degenerate !== want.degenerate) begin
            $error("degenerate expected %0d got %0d", want.degenerate, result.degenerate);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_contact_impulse.sv -----
// tb_contact_impulse: drives contact_impulse with directed and random contacts under
// several register settings and stalls. Depends on ci_pkg, contact_impulse, ci_checker.
`timescale 1ns / 1ps

module tb_contact_impulse;
  import ci_pkg::*;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  item_t    item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  result_t  result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = REG_MASS;
  fx_t      cfg_data = '0;
  int       fails, pending;
  int       cycles = 0;
  int       send_idle = 0, recv_idle = 0, hold_left = 0;
  logic     held = 1'b0;
  int       sent = 0;

  always #2 clk = ~clk;

  contact_impulse dut (.*);

  ci_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (sent >= 950 && !held) begin
      hold_left <= 400;
      held <= 1'b1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic fx_t pick_fx();
    case ($urandom_range(9))
      0: return fx_t'($urandom);
      1: case ($urandom_range(3))
           0: return CI_MAX;
           1: return CI_MIN;
           2: return '0;
           default: return -1;
         endcase
      2: return fx_t'($signed($urandom_range(255)) - 128);
      default: return fx_t'($signed($urandom_range(524288)) - 262144);
    endcase
  endfunction

  function automatic frac_t pick_frac();
    if ($urandom_range(7) == 0) return frac_t'($urandom);
    return frac_t'($urandom_range(65536));
  endfunction

  function automatic item_t random_contact();
    item_t x;
    x.arm_x = pick_fx();  x.arm_y = pick_fx();  x.arm_z = pick_fx();
    x.vel_x = pick_fx();  x.vel_y = pick_fx();  x.vel_z = pick_fx();
    x.norm_x = pick_fx(); x.norm_y = pick_fx(); x.norm_z = pick_fx();
    x.bounce = pick_frac();
    x.grip = pick_frac();
    return x;
  endfunction

  task automatic send(item_t x);
    if (sent < 460) begin
      send_idle = 19; recv_idle = 73;
    end else if (sent < 920) begin
      send_idle = 73; recv_idle = 19;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, fx_t value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_body(fx_t m, fx_t xx, fx_t yy, fx_t zz, fx_t xy, fx_t xz, fx_t yz);
    settle();
    write_reg(REG_MASS, m);
    write_reg(REG_IXX, xx);
    write_reg(REG_IYY, yy);
    write_reg(REG_IZZ, zz);
    write_reg(REG_IXY, xy);
    write_reg(REG_IXZ, xz);
    write_reg(REG_IYZ, yz);
  endtask

  task automatic random_run(int count);
    repeat (count) send(random_contact());
  endtask

  initial begin
    item_t x;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed contacts at reset settings
    x = '0;
    x.norm_y = CI_ONE; x.vel_y = -CI_ONE; x.arm_x = CI_ONE;
    send(x);
    x.bounce = 17'd65536; send(x);
    x.grip = 17'd65536; x.vel_x = CI_ONE; send(x);
    x.bounce = '1; x.grip = '1; send(x);
    x.bounce = '0; x.grip = '0; send(x);
    x = '0; send(x);
    x.norm_x = fx_t'(100); x.vel_x = CI_ONE; send(x);
    x = '0;
    x.arm_x = CI_MAX; x.arm_y = CI_MAX; x.arm_z = CI_MAX;
    x.vel_x = CI_MAX; x.vel_y = CI_MAX; x.vel_z = CI_MAX;
    x.norm_x = CI_MAX; x.norm_y = CI_MAX; x.norm_z = CI_MAX;
    x.bounce = '1; x.grip = '1;
    send(x);
    x.arm_x = CI_MIN; x.arm_y = CI_MIN; x.arm_z = CI_MIN;
    x.vel_x = CI_MIN; x.vel_y = CI_MIN; x.vel_z = CI_MIN;
    x.norm_x = CI_MIN; x.norm_y = CI_MIN; x.norm_z = CI_MIN;
    send(x);
    x.norm_x = CI_MAX; x.vel_y = CI_MAX; x.bounce = '0;
    send(x);
    x = '1; send(x);
    x = '0;
    x.norm_z = -CI_ONE; x.vel_z = CI_ONE; x.arm_x = CI_ONE; x.arm_y = -CI_ONE;
    x.bounce = 17'd32768; x.grip = 17'd32768;
    send(x);
    random_run(280);

    // heavy body, saturated inertia, unknown register index
    load_body(fx_t'(32'h7fffffff), CI_MAX, CI_MAX, CI_MAX, CI_MIN, CI_MIN, CI_MIN);
    write_reg(cfg_idx_t'(7), CI_MAX);
    random_run(280);

    // mass field of zero (top bit dropped)
    load_body(CI_MIN, CI_ONE, CI_ONE, CI_ONE, '0, '0, '0);
    random_run(120);

    // negative unit inertia lets the denominator cancel
    load_body(CI_ONE, -CI_ONE, -CI_ONE, -CI_ONE, '0, '0, '0);
    x = '0;
    x.norm_x = CI_ONE; x.arm_y = CI_ONE; x.vel_x = CI_ONE;
    send(x);
    random_run(280);

    // singular inertia
    load_body(fx_t'(1), '0, '0, '0, '0, '0, '0);
    random_run(120);

    load_body(fx_t'($urandom_range(32'h00100000, 1)),
              fx_t'($urandom_range(32'h00080000, 32'h00008000)),
              fx_t'($urandom_range(32'h00080000, 32'h00008000)),
              fx_t'($urandom_range(32'h00080000, 32'h00008000)),
              fx_t'($signed($urandom_range(32768)) - 16384),
              fx_t'($signed($urandom_range(32768)) - 16384),
              fx_t'($signed($urandom_range(32768)) - 16384));
    random_run(280);

    settle();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
